>>> hw/rtl/ipt_pkg.sv
`timescale 1ns / 1ps

package ipt_pkg;

    localparam int ADDR_W  = 32;
    localparam int CNT_W   = 32;
    localparam int REQ_W   = 16;
    localparam int RPT_W   = 6;
    localparam int ENTRY_W = ADDR_W + CNT_W;

    localparam logic [RPT_W-1:0] RPT_RESET = 6'd10;
    localparam logic [RPT_W-1:0] RPT_MAX   = 6'd32;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_ADD,
        ST_UPDATE,
        ST_APPEND,
        ST_SCAN_RPT,
        ST_EMIT
    } state_t;

endpackage

>>> hw/rtl/ip_request_tally_top_n.sv
`timescale 1ns / 1ps
// Request tally with top-N report. An add item (tuser = 0) walks the table one
// entry per cycle through a simple dual-port RAM looking for its address; on a hit
// the count is added with saturation, on a miss the address is appended, or
// dropped with the sticky overflow flag set when the table is full. A report
// item (tuser = 1) emits the top N = min(report_count clamped to 1..32,
// occupancy) entries, count descending then address ascending, with dense
// ranks; each result is one full selection pass over the table. An empty
// table yields one result with tuser set. The input is not ready while an item
// is in progress. report_count may be written at any time on the cfg channel
// and is sampled when a report item is accepted.

module ip_request_tally_top_n
    import ipt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,     // report_count

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,      // addr[31:0], request_count[47:32]
    input  logic        s_tuser,      // op

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,      // rank[5:0], entry_address[37:6],
                                      // total_requests[69:38], overflowed[70]
    output logic        m_tuser,      // table_empty
    output logic        m_tlast       // last_of_report
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (OCC_W > RPT_W) ? OCC_W : RPT_W;
    localparam logic [OCC_W-1:0] DEPTH_FULL = OCC_W'(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic [RPT_W-1:0]   rpt_cnt_reg, rpt_cnt_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic               ovf_reg, ovf_next;
    logic [OCC_W-1:0]   iss_idx_reg, iss_idx_next;
    logic               dv_reg, dv_next;
    logic [IDX_W-1:0]   d_idx_reg, d_idx_next;
    logic [RPT_W-1:0]   n_reg, n_next;
    logic [RPT_W-1:0]   k_reg, k_next;
    logic [RPT_W-1:0]   rank_reg, rank_next;
    logic               best_valid_reg, best_valid_next;
    logic               empty_reg, empty_next;
    logic               m_valid_reg, m_valid_next;

    logic [ADDR_W-1:0]  in_addr_reg, in_addr_next;
    logic [REQ_W-1:0]   in_cnt_reg, in_cnt_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic [ENTRY_W-1:0] prev_key_reg, prev_key_next;
    logic [ENTRY_W-1:0] best_key_reg, best_key_next;
    logic [RPT_W-1:0]   o_rank_reg, o_rank_next;
    logic [ADDR_W-1:0]  o_addr_reg, o_addr_next;
    logic [CNT_W-1:0]   o_total_reg, o_total_next;
    logic               o_empty_reg, o_empty_next;
    logic               o_ovf_reg, o_ovf_next;
    logic               o_last_reg, o_last_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;

    logic               issuing;
    logic               scan_done;
    logic [ADDR_W-1:0]  rd_addr_f;
    logic [CNT_W-1:0]   rd_cnt_f;
    logic [ENTRY_W-1:0] rd_key;
    logic               after_prev;
    logic               beats_best;
    logic [CNT_W:0]     sat_sum;
    logic [RPT_W-1:0]   rc_eff;
    logic [CMP_W-1:0]   rc_ext;
    logic [CMP_W-1:0]   occ_ext;
    logic               out_free;
    logic [RPT_W-1:0]   rank_cand;

    ipt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (iss_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, o_ovf_reg, o_total_reg, o_addr_reg, o_rank_reg};
    assign m_tuser  = o_empty_reg;
    assign m_tlast  = o_last_reg;

    // Entry word: count in the upper half, address in the lower half.
    assign rd_addr_f = rd_data[ADDR_W-1:0];
    assign rd_cnt_f  = rd_data[ENTRY_W-1:ADDR_W];
    // Larger key ranks first: count descending, then address ascending.
    assign rd_key    = {rd_cnt_f, ~rd_addr_f};

    assign issuing   = ((state_reg == ST_SCAN_ADD) || (state_reg == ST_SCAN_RPT))
                       && (iss_idx_reg < occ_reg);
    assign scan_done = (iss_idx_reg == occ_reg) && !dv_reg;

    assign after_prev = (k_reg == '0) || (rd_key < prev_key_reg);
    assign beats_best = !best_valid_reg || (rd_key > best_key_reg);

    assign sat_sum  = {1'b0, hit_cnt_reg} + {{(CNT_W + 1 - REQ_W){1'b0}}, in_cnt_reg};

    assign rc_eff  = (rpt_cnt_reg == '0) ? RPT_W'(1) :
                     (rpt_cnt_reg > RPT_MAX) ? RPT_MAX : rpt_cnt_reg;
    assign rc_ext  = CMP_W'(rc_eff);
    assign occ_ext = CMP_W'(occ_reg);

    assign out_free  = !m_valid_reg || m_tready;
    assign rank_cand = ((k_reg != '0) && (best_key_reg[ENTRY_W-1:ADDR_W]
                        != prev_key_reg[ENTRY_W-1:ADDR_W])) ? rank_reg + RPT_W'(1)
                                                              : rank_reg;

    always_comb
    begin
        state_next      = state_reg;
        rpt_cnt_next    = rpt_cnt_reg;
        occ_next        = occ_reg;
        ovf_next        = ovf_reg;
        iss_idx_next    = iss_idx_reg;
        dv_next         = issuing;
        d_idx_next      = iss_idx_reg[IDX_W-1:0];
        n_next          = n_reg;
        k_next          = k_reg;
        rank_next       = rank_reg;
        best_valid_next = best_valid_reg;
        empty_next      = empty_reg;
        m_valid_next    = m_valid_reg;

        in_addr_next    = in_addr_reg;
        in_cnt_next     = in_cnt_reg;
        hit_idx_next    = hit_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        prev_key_next   = prev_key_reg;
        best_key_next   = best_key_reg;
        o_rank_next     = o_rank_reg;
        o_addr_next     = o_addr_reg;
        o_total_next    = o_total_reg;
        o_empty_next    = o_empty_reg;
        o_ovf_next      = o_ovf_reg;
        o_last_next     = o_last_reg;

        wr_en   = 1'b0;
        wr_addr = hit_idx_reg;
        wr_data = {sat_sum[CNT_W] ? {CNT_W{1'b1}} : sat_sum[CNT_W-1:0], in_addr_reg};

        if (cfg_valid)
        begin
            rpt_cnt_next = cfg_data;
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (issuing)
        begin
            iss_idx_next = iss_idx_reg + OCC_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                iss_idx_next    = '0;
                best_valid_next = 1'b0;
                k_next          = '0;
                rank_next       = RPT_W'(1);
                if (s_tvalid)
                begin
                    in_addr_next = s_tdata[ADDR_W-1:0];
                    in_cnt_next  = s_tdata[ADDR_W+REQ_W-1:ADDR_W];
                    if (s_tuser == OP_ADD)
                    begin
                        state_next = ST_SCAN_ADD;
                    end
                    else if (occ_reg == '0)
                    begin
                        empty_next = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        empty_next = 1'b0;
                        n_next     = (occ_ext < rc_ext) ? occ_ext[RPT_W-1:0] : rc_eff;
                        state_next = ST_SCAN_RPT;
                    end
                end
            end

            ST_SCAN_ADD:
            begin
                if (dv_reg && (rd_addr_f == in_addr_reg))
                begin
                    hit_idx_next = d_idx_reg;
                    hit_cnt_next = rd_cnt_f;
                    state_next   = ST_UPDATE;
                end
                else if (scan_done)
                begin
                    state_next = ST_APPEND;
                end
            end

            ST_UPDATE:
            begin
                wr_en      = 1'b1;
                state_next = ST_IDLE;
            end

            ST_APPEND:
            begin
                if (occ_reg < DEPTH_FULL)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = occ_reg[IDX_W-1:0];
                    wr_data  = {{(CNT_W - REQ_W){1'b0}}, in_cnt_reg, in_addr_reg};
                    occ_next = occ_reg + OCC_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                state_next = ST_IDLE;
            end

            ST_SCAN_RPT:
            begin
                if (dv_reg && after_prev && beats_best)
                begin
                    best_valid_next = 1'b1;
                    best_key_next   = rd_key;
                end
                if (scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    o_ovf_next   = ovf_reg;
                    if (empty_reg)
                    begin
                        o_rank_next  = '0;
                        o_addr_next  = '0;
                        o_total_next = '0;
                        o_empty_next = 1'b1;
                        o_last_next  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        o_rank_next     = rank_cand;
                        o_addr_next     = ~best_key_reg[ADDR_W-1:0];
                        o_total_next    = best_key_reg[ENTRY_W-1:ADDR_W];
                        o_empty_next    = 1'b0;
                        o_last_next     = ((k_reg + RPT_W'(1)) == n_reg);
                        rank_next       = rank_cand;
                        prev_key_next   = best_key_reg;
                        k_next          = k_reg + RPT_W'(1);
                        best_valid_next = 1'b0;
                        iss_idx_next    = '0;
                        state_next      = ((k_reg + RPT_W'(1)) == n_reg) ? ST_IDLE
                                                                          : ST_SCAN_RPT;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rpt_cnt_reg    <= RPT_RESET;
            occ_reg        <= '0;
            ovf_reg        <= 1'b0;
            iss_idx_reg    <= '0;
            dv_reg         <= 1'b0;
            d_idx_reg      <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            rank_reg       <= '0;
            best_valid_reg <= 1'b0;
            empty_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rpt_cnt_reg    <= rpt_cnt_next;
            occ_reg        <= occ_next;
            ovf_reg        <= ovf_next;
            iss_idx_reg    <= iss_idx_next;
            dv_reg         <= dv_next;
            d_idx_reg      <= d_idx_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            rank_reg       <= rank_next;
            best_valid_reg <= best_valid_next;
            empty_reg      <= empty_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_addr_reg  <= in_addr_next;
        in_cnt_reg   <= in_cnt_next;
        hit_idx_reg  <= hit_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        prev_key_reg <= prev_key_next;
        best_key_reg <= best_key_next;
        o_rank_reg   <= o_rank_next;
        o_addr_reg   <= o_addr_next;
        o_total_reg  <= o_total_next;
        o_empty_reg  <= o_empty_next;
        o_ovf_reg    <= o_ovf_next;
        o_last_reg   <= o_last_next;
    end

endmodule

>>> hw/rtl/ipt_ram.sv
`timescale 1ns / 1ps

module ipt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb
    import ipt_pkg::*;
();

    localparam int DEPTH         = 32;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 4_000_000;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [REQ_W-1:0]  count;
    } tally_req_t;

    typedef struct packed {
        logic [RPT_W-1:0]  rank;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  total;
        logic              empty;
        logic              overflow;
        logic              last;
    } rank_line_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;     // addr[31:0], request_count[47:32]
    logic        s_tuser   = 1'b0;   // op
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;            // rank[5:0], entry_address[37:6],
                                     // total_requests[69:38], overflowed[70]
    logic        m_tuser;            // table_empty
    logic        m_tlast;            // last_of_report

    ip_request_tally_top_n #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // shadow of the address table
    logic [ADDR_W-1:0] tally_addr  [DEPTH];
    logic [CNT_W-1:0]  tally_count [DEPTH];
    int                tally_used      = 0;
    logic              overflow_sticky = 1'b0;
    logic [RPT_W-1:0]  report_limit    = RPT_RESET;

    tally_req_t        request_queue [$];
    rank_line_t        expected_lines [$];
    logic [ADDR_W-1:0] addr_pool [$];
    tally_req_t        on_bus;
    bit                bus_busy = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    logic [RPT_W-1:0] cfg_plan [12] = '{6'd32, 6'd2, 6'd63, 6'd17, 6'd0, 6'd5,
                                        6'd42, 6'd1, 6'd31, 6'd21, 6'd3, 6'd12};

    function automatic void tally_add(input logic [ADDR_W-1:0] a,
                                      input logic [REQ_W-1:0] c);
        logic [CNT_W:0] sum;
        for (int i = 0; i < tally_used; i++)
        begin
            if (tally_addr[i] == a)
            begin
                sum = {1'b0, tally_count[i]} + {{(CNT_W + 1 - REQ_W){1'b0}}, c};
                tally_count[i] = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
                return;
            end
        end
        if (tally_used < DEPTH)
        begin
            tally_addr[tally_used]  = a;
            tally_count[tally_used] = {{(CNT_W - REQ_W){1'b0}}, c};
            tally_used++;
        end
        else
        begin
            overflow_sticky = 1'b1;
        end
    endfunction

    // selection by count descending, then address ascending, dense ranks
    function automatic void rank_table();
        bit         taken [DEPTH] = '{default: 1'b0};
        int         n;
        int         best;
        int         rank_now;
        rank_line_t line;
        line = '0;
        line.overflow = overflow_sticky;
        if (tally_used == 0)
        begin
            line.empty = 1'b1;
            line.last  = 1'b1;
            expected_lines.push_back(line);
            return;
        end
        n = report_limit;
        if (n == 0)
            n = 1;
        if (n > RPT_MAX)
            n = RPT_MAX;
        if (n > tally_used)
            n = tally_used;
        rank_now = 1;
        for (int k = 0; k < n; k++)
        begin
            best = -1;
            for (int i = 0; i < tally_used; i++)
            begin
                if (!taken[i] && (best < 0 || tally_count[i] > tally_count[best] ||
                    (tally_count[i] == tally_count[best] && tally_addr[i] < tally_addr[best])))
                    best = i;
            end
            // line.total still holds the previous entry's count here
            if (k > 0 && tally_count[best] != line.total)
                rank_now++;
            taken[best] = 1'b1;
            line.rank  = RPT_W'(rank_now);
            line.addr  = tally_addr[best];
            line.total = tally_count[best];
            line.last  = (k == n - 1);
            expected_lines.push_back(line);
        end
    endfunction

    function automatic void queue_add(input logic [ADDR_W-1:0] a, input logic [REQ_W-1:0] c);
        tally_req_t r;
        r.op    = OP_ADD;
        r.addr  = a;
        r.count = c;
        request_queue.push_back(r);
        addr_pool.push_back(a);
    endfunction

    function automatic void queue_report();
        tally_req_t r;
        r.op    = OP_REPORT;
        r.addr  = $urandom;
        r.count = REQ_W'($urandom);
        request_queue.push_back(r);
    endfunction

    function automatic tally_req_t random_request();
        tally_req_t r;
        int         pick;
        int         span;
        r.op    = ($urandom_range(99) < 20) ? OP_REPORT : OP_ADD;
        r.addr  = $urandom;
        r.count = REQ_W'($urandom);
        if (r.op == OP_ADD)
        begin
            span = (addr_pool.size() > 40) ? 40 : addr_pool.size();
            pick = $urandom_range(99);
            if (pick < 60 && span > 0)
                r.addr = addr_pool[$urandom_range(span - 1)];
            else if (pick < 75 && span > 0)
                // one bit away from a known address
                r.addr = addr_pool[$urandom_range(span - 1)] ^ (32'h1 << $urandom_range(31));
            else if (pick < 78)
                r.addr = (pick[0]) ? '1 : '0;
            if (pick >= 60)
                addr_pool.push_back(r.addr);
            pick = $urandom_range(99);
            if (pick < 30)
                r.count = REQ_W'($urandom_range(3));
            else if (pick < 40)
                r.count = '1;
        end
        return r;
    endfunction

    task automatic wait_idle();
        while (request_queue.size() > 0 || bus_busy || expected_lines.size() > 0)
            @(posedge clk);
        // an add has no result, so give it time to finish
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_report_count(input logic [RPT_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        report_limit = v;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (on_bus.op == OP_REPORT)
                    rank_table();
                else
                    tally_add(on_bus.addr, on_bus.count);
                bus_busy = 1'b0;
            end
            if (!s_tvalid || s_tready)
            begin
                if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus   = request_queue.pop_front();
                    bus_busy = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tuser  <= on_bus.op;
                    s_tdata  <= {on_bus.count, on_bus.addr};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        rank_line_t got;
        rank_line_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.rank     = m_tdata[5:0];
                got.addr     = m_tdata[37:6];
                got.total    = m_tdata[69:38];
                got.overflow = m_tdata[70];
                got.empty    = m_tuser;
                got.last     = m_tlast;
                if (expected_lines.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: rank %0d addr %h total %h empty %b ovf %b last %b",
                                 got.rank, got.addr, got.total, got.empty, got.overflow,
                                 got.last);
                end
                else
                begin
                    want = expected_lines.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: exp rank %0d addr %h total %h empty %b ovf %b last %b",
                                     want.rank, want.addr, want.total, want.empty,
                                     want.overflow, want.last);
                            $display("          got rank %0d addr %h total %h empty %b ovf %b last %b",
                                     got.rank, got.addr, got.total, got.empty,
                                     got.overflow, got.last);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 68;

        // report on an empty table, with the reset report length
        queue_report();
        queue_add('1, '1);
        queue_add('1, 16'd1);
        queue_add('0, '0);
        queue_add(32'hC0A8_0001, 16'd5);
        queue_add(32'hC0A8_0002, 16'd5);
        queue_add(32'h40A8_0001, 16'd5);
        queue_add(32'hC0A8_0001, 16'd0);
        queue_add(32'h8000_0000, 16'h8000);
        queue_add(32'h7FFF_FFFF, 16'h7FFF);
        queue_report();

        wait_idle();
        write_report_count(6'd1);
        queue_report();
        wait_idle();
        write_report_count(6'd0);
        queue_report();
        wait_idle();
        write_report_count(6'd63);
        queue_report();

        for (int phase = 0; phase < 3; phase++)
        begin
            for (int chunk = 0; chunk < 4; chunk++)
            begin
                wait_idle();
                if (chunk == 0)
                begin
                    send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 68 : 0;
                    recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 9 : 0;
                end
                write_report_count(cfg_plan[phase * 4 + chunk]);
                repeat (22) request_queue.push_back(random_request());
            end
        end

        // make sure the table fills and an add gets dropped
        wait_idle();
        write_report_count(RPT_MAX);
        repeat (DEPTH + 1) queue_add($urandom, REQ_W'($urandom_range(1, 16'hFFFF)));
        queue_report();

        wait_idle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ipt_pkg.sv
hw/rtl/ipt_ram.sv
hw/rtl/ip_request_tally_top_n.sv
bench/tb.sv
